// ===== hw/rtl/pmlu_pkg.sv =====
// Shared types, codes and sizes for the priority mutex lock unit.
`default_nettype none

package pmlu_pkg;

  // Wait queue geometry.
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);

  // Recursion limit: the smaller of the configured maximum and what eight bits hold.
  localparam int unsigned MaxRecursion = 255;
  localparam logic [7:0]  DepthLimit   = 8'((MaxRecursion < 255) ? MaxRecursion : 255);

  // Request codes.
  typedef enum logic [1:0] {
    OpLock    = 2'd0,
    OpTrylock = 2'd1,
    OpUnlock  = 2'd2,
    OpDestroy = 2'd3
  } op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StBlocked  = 3'd1,
    StDeadlock = 3'd2,
    StBusy     = 3'd3,
    StNotOwner = 3'd4,
    StQueueFull = 3'd5,
    StDepthOvf = 3'd6
  } status_e;

  // Configuration register indexes.
  localparam logic [1:0] CfgMutexKind = 2'd0;
  localparam logic [1:0] CfgProtocol  = 2'd1;
  localparam logic [1:0] CfgCeiling   = 2'd2;

  // Configuration codes that change behavior; all others act as the default.
  localparam logic [1:0] KindRecursive = 2'd2;
  localparam logic [1:0] ProtoProtect  = 2'd2;

  // One queued waiter.
  typedef struct packed {
    logic [7:0] id;
    logic [7:0] prio;
  } waiter_t;

  // Command broadcast to every cell of the wait queue.
  typedef struct packed {
    logic    insert;
    logic    remove;
    waiter_t entry;
  } queue_cmd_t;

  // One result word.
  typedef struct packed {
    status_e    status;
    logic       owner_valid;
    logic [7:0] owner_id;
    logic [7:0] lock_depth;
    logic       set_prio_valid;
    logic [7:0] set_prio_value;
    logic       handoff_valid;
    logic [7:0] handoff_id;
    logic       boost_valid;
    logic [7:0] boost_prio;
    logic       drop_boost;
    logic       reschedule;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pmlu_wait_cell.sv =====
// One cell of the sorted wait queue: holds a waiter and trades with its neighbors.
`default_nettype none

module pmlu_wait_cell
  import pmlu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       occupied_i,
  input  wire queue_cmd_t cmd_i,
  input  wire logic       prev_stay_i,
  input  wire waiter_t    prev_entry_i,
  input  wire waiter_t    next_entry_i,
  output logic            stay_o,
  output waiter_t         entry_o
);

  waiter_t entry_q, entry_d;

  // A waiter of equal or higher priority keeps its place, so equals stay FIFO.
  assign stay_o  = occupied_i && (entry_q.prio >= cmd_i.entry.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.insert) begin
      if (!stay_o) begin
        entry_d = prev_stay_i ? cmd_i.entry : prev_entry_i;
      end
    end else if (cmd_i.remove) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/pmlu_wait_queue.sv =====
// Priority-sorted wait queue built as a chain of cells with a fill count.
`default_nettype none

module pmlu_wait_queue
  import pmlu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire queue_cmd_t  cmd_i,
  output waiter_t          head_o,
  output logic [CountW-1:0] count_o
);

  logic [CountW-1:0] count_q, count_d;
  waiter_t           entries [QueueDepth];
  logic              stays   [QueueDepth];

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    logic    prev_stay;
    waiter_t prev_entry;
    waiter_t next_entry;

    if (i == 0) begin : g_first
      // The head has no predecessor, so it takes the new waiter when it yields.
      assign prev_stay  = 1'b1;
      assign prev_entry = '0;
    end else begin : g_mid
      assign prev_stay  = stays[i-1];
      assign prev_entry = entries[i-1];
    end

    if (i == QueueDepth - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_inner
      assign next_entry = entries[i+1];
    end

    pmlu_wait_cell u_cell (
      .clk_i        (clk_i),
      .occupied_i   (CountW'(i) < count_q),
      .cmd_i        (cmd_i),
      .prev_stay_i  (prev_stay),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .stay_o       (stays[i]),
      .entry_o      (entries[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CountW'(1);
    end else if (cmd_i.remove) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign head_o  = entries[0];
  assign count_o = count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/priority_mutex_lock_unit.sv =====
// Top level of the priority mutex lock unit: owner state, request decode and result register.
//
//   Channel   Direction  Handshake                  Contents
//   request   in         in_valid_i / in_stall_o    op, thread id, priority, already waiting
//   result    out        out_valid_o / out_stall_i  status, owner, depth, priority actions
//   config    in         cfg_we_i                   kind, protocol, ceiling (index, data)
//
// A request word is captured into a request register. Once the output register is free or
// being emptied, the owner logic and the wait queue's cell chain update together while
// the result word is loaded into the output register. A new word is accepted only after
// the pending one executes. The cell chain inserts or removes a waiter with all cells
// updating together. Reset clears the owner state, the waiter count and both handshakes
// at once; queue cells hold no reset value. While a result waits under out_stall_i, one
// more request word is accepted and held until the output register frees up.
`default_nettype none

module priority_mutex_lock_unit
  import pmlu_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // Configuration write port.
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  // Request channel.
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] thread_id_i,
  input  wire logic [7:0] thread_priority_i,
  input  wire logic       already_waiting_i,
  // Result channel.
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [2:0]      status_o,
  output logic            owner_valid_o,
  output logic [7:0]      owner_id_o,
  output logic [7:0]      lock_depth_o,
  output logic            set_priority_valid_o,
  output logic [7:0]      set_priority_value_o,
  output logic            handoff_valid_o,
  output logic [7:0]      handoff_id_o,
  output logic            boost_valid_o,
  output logic [7:0]      boost_priority_o,
  output logic            drop_boost_o,
  output logic            reschedule_o
);

  // Configuration registers.
  logic [1:0] kind_q;
  logic [1:0] proto_q;
  logic [7:0] ceiling_q;

  // Request register.
  logic       req_valid_q;
  op_e        op_q;
  logic [7:0] tid_q;
  logic [7:0] tprio_q;
  logic       wait_q;

  // Mutex owner state.
  logic       held_q, held_d;
  logic [7:0] holder_id_q, holder_id_d;
  logic [7:0] holder_prio_q, holder_prio_d;
  logic [7:0] depth_q, depth_d;
  logic [7:0] saved_prio_q, saved_prio_d;

  // Result register.
  logic       out_valid_q;
  result_t    res_q, res_d;

  // Wait queue interface.
  queue_cmd_t        cmd, queue_cmd;
  waiter_t           head;
  logic [CountW-1:0] q_count;

  logic recursive;
  logic protect;
  logic is_owner;
  logic fire;
  logic in_accept;
  logic out_taken;

  assign recursive = (kind_q == KindRecursive);
  assign protect   = (proto_q == ProtoProtect);
  assign is_owner  = held_q && (holder_id_q == tid_q);

  // The pending request executes once the output register is free or being emptied.
  assign fire      = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q;
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_taken = out_valid_q && !out_stall_i;

  // Request decode and next owner state.
  always_comb begin
    logic [7:0] releaser_prio;

    held_d        = held_q;
    holder_id_d   = holder_id_q;
    holder_prio_d = holder_prio_q;
    depth_d       = depth_q;
    saved_prio_d  = saved_prio_q;
    releaser_prio = tprio_q;

    cmd            = '0;
    cmd.entry.id   = tid_q;
    cmd.entry.prio = tprio_q;

    res_d        = '0;
    res_d.status = StOk;

    unique case (op_q)
      OpLock, OpTrylock: begin
        if (!held_q) begin
          held_d        = 1'b1;
          holder_id_d   = tid_q;
          depth_d       = 8'd1;
          holder_prio_d = tprio_q;
          if (protect) begin
            saved_prio_d         = tprio_q;
            holder_prio_d        = ceiling_q;
            res_d.set_prio_valid = 1'b1;
            res_d.set_prio_value = ceiling_q;
          end
        end else if (is_owner) begin
          if (!recursive) begin
            res_d.status = StDeadlock;
          end else if (depth_q >= DepthLimit) begin
            res_d.status = StDepthOvf;
          end else begin
            depth_d = depth_q + 8'd1;
          end
        end else if (op_q == OpTrylock) begin
          res_d.status = StBusy;
        end else if (wait_q) begin
          res_d.status = StDeadlock;
        end else if (q_count == CountW'(QueueDepth)) begin
          res_d.status = StQueueFull;
        end else begin
          // Queue the requester and raise a lower-priority owner.
          cmd.insert   = 1'b1;
          res_d.status = StBlocked;
          if (holder_prio_q < tprio_q) begin
            res_d.boost_valid = 1'b1;
            res_d.boost_prio  = tprio_q;
            holder_prio_d     = tprio_q;
          end
        end
      end

      OpUnlock: begin
        if (!is_owner) begin
          res_d.status = StNotOwner;
        end else if (recursive && (depth_q > 8'd1)) begin
          depth_d = depth_q - 8'd1;
        end else begin
          if (protect) begin
            res_d.set_prio_valid = 1'b1;
            res_d.set_prio_value = saved_prio_q;
            releaser_prio        = saved_prio_q;
          end
          res_d.drop_boost = 1'b1;
          if (q_count != '0) begin
            // Hand the mutex to the head of the queue.
            cmd.remove    = 1'b1;
            holder_id_d   = head.id;
            depth_d       = 8'd1;
            holder_prio_d = head.prio;
            if (protect) begin
              saved_prio_d  = head.prio;
              holder_prio_d = ceiling_q;
            end
            res_d.handoff_valid = 1'b1;
            res_d.handoff_id    = head.id;
            res_d.reschedule    = (holder_prio_d > releaser_prio);
          end else begin
            held_d        = 1'b0;
            holder_id_d   = '0;
            holder_prio_d = '0;
            depth_d       = '0;
          end
        end
      end

      OpDestroy: begin
        if (held_q && !(recursive && is_owner)) begin
          res_d.status = StBusy;
        end else begin
          // A recursive owner drops its lock first; waiters still keep it busy.
          held_d        = 1'b0;
          holder_id_d   = '0;
          holder_prio_d = '0;
          depth_d       = '0;
          if (q_count != '0) begin
            res_d.status = StBusy;
          end else begin
            saved_prio_d = '0;
          end
        end
      end

      default: ;
    endcase

    res_d.owner_valid = held_d;
    res_d.owner_id    = held_d ? holder_id_d : '0;
    res_d.lock_depth  = depth_d;
  end

  assign queue_cmd = fire ? cmd : '0;

  pmlu_wait_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (queue_cmd),
    .head_o  (head),
    .count_o (q_count)
  );

  // Configuration writes; an index beyond the register list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= 2'd0;
      proto_q   <= 2'd0;
      ceiling_q <= 8'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgMutexKind: kind_q    <= cfg_data_i[1:0];
        CfgProtocol:  proto_q   <= cfg_data_i[1:0];
        CfgCeiling:   ceiling_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Request register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (in_accept) begin
      req_valid_q <= 1'b1;
    end else if (fire) begin
      req_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= op_e'(op_i);
      tid_q   <= thread_id_i;
      tprio_q <= thread_priority_i;
      wait_q  <= already_waiting_i;
    end
  end

  // Owner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q        <= 1'b0;
      holder_id_q   <= '0;
      holder_prio_q <= '0;
      depth_q       <= '0;
      saved_prio_q  <= '0;
    end else if (fire) begin
      held_q        <= held_d;
      holder_id_q   <= holder_id_d;
      holder_prio_q <= holder_prio_d;
      depth_q       <= depth_d;
      saved_prio_q  <= saved_prio_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_taken) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = res_q.status;
  assign owner_valid_o        = res_q.owner_valid;
  assign owner_id_o           = res_q.owner_id;
  assign lock_depth_o         = res_q.lock_depth;
  assign set_priority_valid_o = res_q.set_prio_valid;
  assign set_priority_value_o = res_q.set_prio_value;
  assign handoff_valid_o      = res_q.handoff_valid;
  assign handoff_id_o         = res_q.handoff_id;
  assign boost_valid_o        = res_q.boost_valid;
  assign boost_priority_o     = res_q.boost_prio;
  assign drop_boost_o         = res_q.drop_boost;
  assign reschedule_o         = res_q.reschedule;

`ifndef ASSERT_OFF
  // An accepted word is always waiting in the request register in the following cycle.
  a_accept_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> req_valid_q)
    else $error("accepted request word not pending");

  // The fill count of the wait queue never runs past its depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= CountW'(QueueDepth))
    else $error("wait queue count beyond depth");

  // A free mutex reports no owner and no depth.
  a_free_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !owner_valid_o) |-> (owner_id_o == '0 && lock_depth_o == '0))
    else $error("free mutex reports owner or depth");

  // A handoff leaves the granted waiter as the owner at depth one.
  a_handoff_owner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && handoff_valid_o)
      |-> (owner_valid_o && owner_id_o == handoff_id_o && lock_depth_o == 8'd1))
    else $error("handoff does not match new owner");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/priority_mutex_lock_unit_tb.sv =====
// Self-checking testbench for the priority mutex lock unit, with its own model of the mutex.
module priority_mutex_lock_unit_tb;
  import pmlu_pkg::*;

  // Run shape. About this many request words are sent. Sender and receiver stop idling
  // over the last stretch of them. The receiver holds off once for a long stretch so
  // that the block fills up and stalls its request channel.
  localparam int RequestTarget = 1450;
  localparam int CalmTail      = 150;
  localparam int LongHold      = 80;
  localparam int ReportLimit   = 10;
  localparam int WatchdogTime  = 800000;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [1:0] op_i;
  logic [7:0] thread_id_i;
  logic [7:0] thread_priority_i;
  logic       already_waiting_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] status_o;
  logic       owner_valid_o;
  logic [7:0] owner_id_o;
  logic [7:0] lock_depth_o;
  logic       set_priority_valid_o;
  logic [7:0] set_priority_value_o;
  logic       handoff_valid_o;
  logic [7:0] handoff_id_o;
  logic       boost_valid_o;
  logic [7:0] boost_priority_o;
  logic       drop_boost_o;
  logic       reschedule_o;

  priority_mutex_lock_unit dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .op_i                 (op_i),
    .thread_id_i          (thread_id_i),
    .thread_priority_i    (thread_priority_i),
    .already_waiting_i    (already_waiting_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_o             (status_o),
    .owner_valid_o        (owner_valid_o),
    .owner_id_o           (owner_id_o),
    .lock_depth_o         (lock_depth_o),
    .set_priority_valid_o (set_priority_valid_o),
    .set_priority_value_o (set_priority_value_o),
    .handoff_valid_o      (handoff_valid_o),
    .handoff_id_o         (handoff_id_o),
    .boost_valid_o        (boost_valid_o),
    .boost_priority_o     (boost_priority_o),
    .drop_boost_o         (drop_boost_o),
    .reschedule_o         (reschedule_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Our own copy of the mutex: settings, owner bookkeeping and the sorted wait line.
  logic [1:0] cur_kind;
  logic [1:0] cur_proto;
  logic [7:0] cur_ceiling;
  logic       own_held;
  logic [7:0] own_id;
  logic [7:0] own_prio;
  logic [7:0] own_depth;
  logic [7:0] saved_prio;
  waiter_t    wait_line[$];

  // Result words still owed by the block, oldest first.
  result_t lock_outcomes[$];

  // Handshake control shared between the sender and the receiver.
  bit backlog_hold = 1'b0;
  bit calm_tail    = 1'b0;

  // Tallies for the final report.
  int requests_sent = 0;
  int config_rounds = 0;
  int results_seen  = 0;
  int mismatches    = 0;
  int handoffs      = 0;
  int boosts        = 0;
  int status_tally [8];

  // Rows of the directed opening. A row either changes the settings or sends one request;
  // a request row with known set carries the owner view typed in by hand.
  typedef struct {
    bit         is_cfg;
    logic [1:0] cfg_kind;
    logic [1:0] cfg_proto;
    logic [7:0] cfg_ceil;
    op_e        op;
    logic [7:0] tid;
    logic [7:0] prio;
    logic       waiting;
    bit         known;
    status_e    st;
    logic       ov;
    logic [7:0] oid;
    logic [7:0] depth;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic void release_owner();
    own_held  = 1'b0;
    own_id    = 8'd0;
    own_prio  = 8'd0;
    own_depth = 8'd0;
  endfunction

  // Applies one request to the model and returns the result word it must produce.
  function automatic result_t mutex_step(input op_e op, input logic [7:0] tid,
                                         input logic [7:0] prio, input logic waiting);
    result_t    r;
    waiter_t    head;
    waiter_t    entry;
    logic       recursive;
    logic       protect;
    logic       is_owner;
    logic       busy;
    logic [7:0] releaser;
    int         pos;
    r         = '0;
    r.status  = StOk;
    recursive = (cur_kind == KindRecursive);
    protect   = (cur_proto == ProtoProtect);
    is_owner  = own_held && (own_id == tid);
    case (op)
      OpLock, OpTrylock: begin
        if (!own_held) begin
          own_held  = 1'b1;
          own_id    = tid;
          own_depth = 8'd1;
          own_prio  = prio;
          if (protect) begin
            // The acquirer runs at the ceiling; its own priority is kept for release.
            saved_prio       = prio;
            own_prio         = cur_ceiling;
            r.set_prio_valid = 1'b1;
            r.set_prio_value = cur_ceiling;
          end
        end else if (is_owner) begin
          if (!recursive) r.status = StDeadlock;
          else if (own_depth >= DepthLimit) r.status = StDepthOvf;
          else own_depth = own_depth + 8'd1;
        end else if (op == OpTrylock) begin
          r.status = StBusy;
        end else if (waiting) begin
          r.status = StDeadlock;
        end else if (wait_line.size() >= QueueDepth) begin
          r.status = StQueueFull;
        end else begin
          // Behind every waiter of equal or higher priority.
          pos = 0;
          while (pos < wait_line.size() && wait_line[pos].prio >= prio) pos++;
          entry.id   = tid;
          entry.prio = prio;
          wait_line.insert(pos, entry);
          r.status = StBlocked;
          if (own_prio < prio) begin
            r.boost_valid = 1'b1;
            r.boost_prio  = prio;
            own_prio      = prio;
          end
        end
      end
      OpUnlock: begin
        if (!is_owner) begin
          r.status = StNotOwner;
        end else if (recursive && own_depth > 8'd1) begin
          own_depth = own_depth - 8'd1;
        end else begin
          releaser = prio;
          if (protect) begin
            r.set_prio_valid = 1'b1;
            r.set_prio_value = saved_prio;
            releaser         = saved_prio;
          end
          r.drop_boost = 1'b1;
          if (wait_line.size() > 0) begin
            head      = wait_line.pop_front();
            own_id    = head.id;
            own_depth = 8'd1;
            own_prio  = head.prio;
            if (protect) begin
              saved_prio = head.prio;
              own_prio   = cur_ceiling;
            end
            r.handoff_valid = 1'b1;
            r.handoff_id    = head.id;
            r.reschedule    = (own_prio > releaser);
          end else begin
            release_owner();
          end
        end
      end
      default: begin
        // Destroy: a recursive owner loses its hold first; anything left makes it busy.
        busy = 1'b0;
        if (own_held) begin
          if (recursive && is_owner) release_owner();
          else busy = 1'b1;
        end
        if (!busy && wait_line.size() > 0) busy = 1'b1;
        if (busy) begin
          r.status = StBusy;
        end else begin
          release_owner();
          saved_prio = 8'd0;
        end
      end
    endcase
    r.owner_valid = own_held;
    r.owner_id    = own_held ? own_id : 8'd0;
    r.lock_depth  = own_depth;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf({"status %0d owner %0b/%0d depth %0d setprio %0b/%0d handoff %0b/%0d",
                      " boost %0b/%0d drop %0b resched %0b"},
                     r.status, r.owner_valid, r.owner_id, r.lock_depth, r.set_prio_valid,
                     r.set_prio_value, r.handoff_valid, r.handoff_id, r.boost_valid,
                     r.boost_prio, r.drop_boost, r.reschedule);
  endfunction

  // Priorities lean on the extremes and on a few repeated values so that ties are common.
  function automatic logic [7:0] pick_priority();
    if ($urandom_range(0, 2) == 0) return 8'($urandom_range(0, 3) * 85);
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic plan_req(input op_e op, input logic [7:0] tid, input logic [7:0] prio,
                          input logic waiting);
    plan_row_t row;
    row         = '{op: OpLock, st: StOk, default: '0};
    row.op      = op;
    row.tid     = tid;
    row.prio    = prio;
    row.waiting = waiting;
    plan.push_back(row);
  endtask

  task automatic plan_known(input op_e op, input logic [7:0] tid, input logic [7:0] prio,
                            input logic waiting, input status_e st, input logic ov,
                            input logic [7:0] oid, input logic [7:0] depth);
    plan_row_t row;
    row         = '{op: OpLock, st: StOk, default: '0};
    row.op      = op;
    row.tid     = tid;
    row.prio    = prio;
    row.waiting = waiting;
    row.known   = 1'b1;
    row.st      = st;
    row.ov      = ov;
    row.oid     = oid;
    row.depth   = depth;
    plan.push_back(row);
  endtask

  task automatic plan_cfg(input logic [1:0] kind, input logic [1:0] proto,
                          input logic [7:0] ceiling);
    plan_row_t row;
    row           = '{op: OpLock, st: StOk, default: '0};
    row.is_cfg    = 1'b1;
    row.cfg_kind  = kind;
    row.cfg_proto = proto;
    row.cfg_ceil  = ceiling;
    plan.push_back(row);
  endtask

  // Writes all three registers on consecutive edges. The two-bit registers get random
  // upper data bits, which the block must ignore.
  task automatic program_config(input logic [1:0] kind, input logic [1:0] proto,
                                input logic [7:0] ceiling);
    logic [7:0] kind_word;
    logic [7:0] proto_word;
    kind_word   = {6'($urandom_range(0, 63)), kind};
    proto_word  = {6'($urandom_range(0, 63)), proto};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgMutexKind;
    cfg_data_i  <= kind_word;
    @(posedge clk_i);
    cfg_index_i <= CfgProtocol;
    cfg_data_i  <= proto_word;
    @(posedge clk_i);
    cfg_index_i <= CfgCeiling;
    cfg_data_i  <= ceiling;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_kind    = kind_word[1:0];
    cur_proto   = proto_word[1:0];
    cur_ceiling = ceiling;
    config_rounds++;
  endtask

  // Waits until every result word owed has been taken, so the block is idle.
  task automatic settle();
    while (lock_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // Offers one request word, possibly after a random gap, and returns at the edge that
  // accepts it. Valid stays high on return so a following word can go out back to back.
  task automatic offer(input op_e op, input logic [7:0] tid, input logic [7:0] prio,
                       input logic waiting, input result_t want);
    if (requests_sent >= RequestTarget - CalmTail) calm_tail = 1'b1;
    if (!calm_tail && $urandom_range(0, 9) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    lock_outcomes.push_back(want);
    in_valid_i        <= 1'b1;
    op_i              <= op;
    thread_id_i       <= tid;
    thread_priority_i <= prio;
    already_waiting_i <= waiting;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    requests_sent++;
  endtask

  task automatic request(input op_e op, input logic [7:0] tid, input logic [7:0] prio,
                         input logic waiting);
    offer(op, tid, prio, waiting, mutex_step(op, tid, prio, waiting));
  endtask

  // Releases the mutex until nobody holds it and nobody waits, then destroys it.
  task automatic drain();
    while (own_held) request(OpUnlock, own_id, pick_priority(), 1'($urandom_range(0, 1)));
    request(OpDestroy, 8'($urandom_range(0, 255)), pick_priority(),
            1'($urandom_range(0, 1)));
  endtask

  // A mix of all operations from a small crowd of threads, so that owners relock and
  // unlock often and the wait line grows and shrinks; now and then any thread id at all.
  task automatic mixed_burst(input int count);
    int         roll;
    op_e        op;
    logic [7:0] tid;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) op = OpLock;
      else if (roll < 50) op = OpTrylock;
      else if (roll < 90) op = OpUnlock;
      else op = OpDestroy;
      if ($urandom_range(0, 4) == 0) tid = 8'($urandom_range(0, 255));
      else tid = 8'($urandom_range(0, 5));
      if (own_held && (op == OpUnlock ? $urandom_range(0, 3) != 0 : $urandom_range(0, 5) == 0))
        tid = own_id;
      request(op, tid, pick_priority(), $urandom_range(0, 9) == 0);
    end
  endtask

  // Queues more lockers than the wait line holds, so the last ones see it full, and then
  // hands the mutex down the whole line in priority order.
  task automatic fill_queue();
    logic [7:0] tid;
    if (!own_held) request(OpLock, 8'($urandom_range(0, 255)), pick_priority(), 1'b0);
    repeat (QueueDepth + 2) begin
      tid = 8'($urandom_range(0, 255));
      if (tid == own_id) tid = tid ^ 8'h01;
      request(OpLock, tid, pick_priority(), 1'b0);
    end
    drain();
  endtask

  // Receiver: stalls in random bursts, and once for a long stretch on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left == 0) begin
        if (backlog_hold) begin
          backlog_hold = 1'b0;
          stall_left   = LongHold;
        end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
          stall_left = $urandom_range(1, 12);
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: every result word taken is matched against the oldest one owed.
  result_t seen;
  result_t owed;

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      seen.status         = status_e'(status_o);
      seen.owner_valid    = owner_valid_o;
      seen.owner_id       = owner_id_o;
      seen.lock_depth     = lock_depth_o;
      seen.set_prio_valid = set_priority_valid_o;
      seen.set_prio_value = set_priority_value_o;
      seen.handoff_valid  = handoff_valid_o;
      seen.handoff_id     = handoff_id_o;
      seen.boost_valid    = boost_valid_o;
      seen.boost_prio     = boost_priority_o;
      seen.drop_boost     = drop_boost_o;
      seen.reschedule     = reschedule_o;
      results_seen++;
      status_tally[seen.status]++;
      if (seen.handoff_valid === 1'b1) handoffs++;
      if (seen.boost_valid === 1'b1) boosts++;
      if (lock_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("%0t: result word with no request outstanding: %s", $time, show(seen));
      end else begin
        owed = lock_outcomes.pop_front();
        if (seen !== owed) begin
          mismatches++;
          if (mismatches <= ReportLimit) begin
            $display("%0t: result word %0d differs", $time, results_seen);
            $display("  expected %s", show(owed));
            $display("  actual   %s", show(seen));
          end
        end
      end
    end
  end

  // Watchdog: a correct run ends long before this.
  initial begin
    #(WatchdogTime);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    plan_row_t  row;
    result_t    want;
    logic [7:0] deep_id;
    int         phase;

    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= CfgMutexKind;
    cfg_data_i        <= 8'd0;
    in_valid_i        <= 1'b0;
    op_i              <= OpLock;
    thread_id_i       <= 8'd0;
    thread_priority_i <= 8'd0;
    already_waiting_i <= 1'b0;

    // Model starts from the reset settings: normal kind, no protocol, ceiling one.
    cur_kind    = 2'd0;
    cur_proto   = 2'd0;
    cur_ceiling = 8'd1;
    saved_prio  = 8'd0;
    release_owner();

    // Directed opening, first under the reset settings. Rows with the owner view typed in
    // have no priority actions, so those fields are expected to be zero.
    plan_known(OpUnlock, 8'h05, 8'h10, 1'b0, StNotOwner, 1'b0, 8'h00, 8'd0);
    plan_known(OpDestroy, 8'h00, 8'h00, 1'b0, StOk, 1'b0, 8'h00, 8'd0);
    plan_known(OpLock, 8'h00, 8'h00, 1'b0, StOk, 1'b1, 8'h00, 8'd1);
    // A normal mutex relocked by its owner deadlocks.
    plan_known(OpLock, 8'h00, 8'h00, 1'b0, StDeadlock, 1'b1, 8'h00, 8'd1);
    plan_known(OpTrylock, 8'hff, 8'hff, 1'b1, StBusy, 1'b1, 8'h00, 8'd1);
    // A requester that already blocks elsewhere cannot wait here.
    plan_known(OpLock, 8'h07, 8'h0a, 1'b1, StDeadlock, 1'b1, 8'h00, 8'd1);
    // Waiters: a boost for the low owner, then a tie, a duplicate and a low one at the tail.
    plan_req(OpLock, 8'hff, 8'hff, 1'b0);
    plan_req(OpLock, 8'h09, 8'hff, 1'b0);
    plan_req(OpLock, 8'h09, 8'hff, 1'b0);
    plan_req(OpLock, 8'h30, 8'h40, 1'b0);
    plan_known(OpDestroy, 8'h00, 8'h00, 1'b0, StBusy, 1'b1, 8'h00, 8'd1);
    plan_known(OpUnlock, 8'h03, 8'h00, 1'b0, StNotOwner, 1'b1, 8'h00, 8'd1);
    plan_req(OpUnlock, 8'h00, 8'h00, 1'b0);
    // Recursive kind with the ceiling protocol at the top ceiling.
    plan_cfg(KindRecursive, ProtoProtect, 8'hff);
    plan_req(OpUnlock, 8'hff, 8'h80, 1'b0);
    plan_req(OpLock, 8'h09, 8'h00, 1'b0);
    // Destroy by a recursive owner drops the hold, then stays busy over the waiter.
    plan_req(OpDestroy, 8'h09, 8'h00, 1'b0);
    plan_req(OpLock, 8'h01, 8'h03, 1'b0);
    plan_req(OpUnlock, 8'h01, 8'h03, 1'b0);
    plan_req(OpUnlock, 8'h09, 8'h00, 1'b0);
    plan_req(OpUnlock, 8'h30, 8'h00, 1'b0);
    plan_req(OpDestroy, 8'hc8, 8'h55, 1'b0);
    // The unused kind and protocol codes behave as normal and none; ceiling at zero.
    plan_cfg(2'd3, 2'd3, 8'h00);
    plan_known(OpLock, 8'h04, 8'h80, 1'b0, StOk, 1'b1, 8'h04, 8'd1);
    plan_known(OpLock, 8'h04, 8'h80, 1'b0, StDeadlock, 1'b1, 8'h04, 8'd1);
    plan_req(OpLock, 8'h06, 8'h00, 1'b0);
    plan_req(OpUnlock, 8'h04, 8'h7f, 1'b0);
    plan_req(OpUnlock, 8'h06, 8'h00, 1'b0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_cfg) begin
        in_valid_i <= 1'b0;
        settle();
        program_config(row.cfg_kind, row.cfg_proto, row.cfg_ceil);
      end else begin
        want = mutex_step(row.op, row.tid, row.prio, row.waiting);
        if (row.known) begin
          want             = '0;
          want.status      = row.st;
          want.owner_valid = row.ov;
          want.owner_id    = row.oid;
          want.lock_depth  = row.depth;
        end
        offer(row.op, row.tid, row.prio, row.waiting, want);
      end
    end
    in_valid_i <= 1'b0;

    // Random phases, each under fresh settings written while the block is idle. One phase
    // drives a recursive lock past its depth limit; others fill the wait line to the brim;
    // the rest are mixed traffic. The long receiver hold lands in an early mixed phase.
    phase = 0;
    while (requests_sent < RequestTarget) begin
      settle();
      if (phase == 3) begin
        drain();
        in_valid_i <= 1'b0;
        settle();
        program_config(KindRecursive, 2'($urandom_range(0, 3)), pick_priority());
        deep_id = 8'($urandom_range(0, 255));
        repeat (DepthLimit + 2) request(OpLock, deep_id, pick_priority(), 1'b0);
        request(OpDestroy, deep_id, pick_priority(), 1'b0);
      end else begin
        program_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_priority());
        if (phase == 2) backlog_hold = 1'b1;
        if (phase % 3 == 1) fill_queue();
        else mixed_burst($urandom_range(60, 160));
      end
      in_valid_i <= 1'b0;
      phase++;
    end

    settle();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d requests under %0d settings; %0d result words taken,",
             requests_sent, config_rounds, results_seen);
    $display("%0d handoffs, %0d boosts.", handoffs, boosts);
    $display("Statuses: ok %0d blocked %0d deadlock %0d busy %0d",
             status_tally[StOk], status_tally[StBlocked], status_tally[StDeadlock],
             status_tally[StBusy]);
    $display("notowner %0d full %0d overflow %0d.",
             status_tally[StNotOwner], status_tally[StQueueFull], status_tally[StDepthOvf]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pmlu_pkg.sv
hw/rtl/pmlu_wait_cell.sv
hw/rtl/pmlu_wait_queue.sv
hw/rtl/priority_mutex_lock_unit.sv
tb/sv/priority_mutex_lock_unit_tb.sv
